// File: hw/rtl/bia_pkg.sv
// ----------------------------------------------------------------------------
// bia_pkg
// Shared constants, codes and controller/datapath interface types for the
// buffer id allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bia_pkg;

  localparam int INDEX_BITS  = 12;
  localparam int HANDLE_BITS = 16;
  localparam int TIME_BITS   = 32;
  localparam int ID_BITS     = 31;
  localparam int RESULT_ID_BITS = 32;

  localparam logic [TIME_BITS-1:0]      TIMEOUT_RESET = 32'd1000;
  localparam logic [RESULT_ID_BITS-1:0] NO_BUFFER_ID  = 32'hFFFF_FFFF;

  // request kinds
  localparam logic [1:0] KIND_PUT     = 2'd0;
  localparam logic [1:0] KIND_GET     = 2'd1;
  localparam logic [1:0] KIND_ALIVE   = 2'd2;
  localparam logic [1:0] KIND_DISCARD = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_BUFFER = 2'd1;
  localparam logic [1:0] STAT_UNUSED    = 2'd2;
  localparam logic [1:0] STAT_MISMATCH  = 2'd3;

  // datapath operations
  localparam logic [3:0] OP_IDLE    = 4'd0;
  localparam logic [3:0] OP_CLEAR   = 4'd1;
  localparam logic [3:0] OP_LOAD    = 4'd2;
  localparam logic [3:0] OP_RD_RING = 4'd3;
  localparam logic [3:0] OP_RD_SLOT = 4'd4;
  localparam logic [3:0] OP_AGE     = 4'd5;
  localparam logic [3:0] OP_CLAIM   = 4'd6;
  localparam logic [3:0] OP_RECLAIM = 4'd7;
  localparam logic [3:0] OP_NOBUF   = 4'd8;
  localparam logic [3:0] OP_CHECK   = 4'd9;
  localparam logic [3:0] OP_EMIT    = 4'd10;

  // slot address sources
  localparam logic [1:0] SRC_ID   = 2'd0;
  localparam logic [1:0] SRC_RING = 2'd1;
  localparam logic [1:0] SRC_HEAD = 2'd2;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] src;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_kind;
    logic       free_empty;
    logic       used_empty;
    logic       clr_last;
    logic       age_gt;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/bia_ctrl.sv
// ----------------------------------------------------------------------------
// bia_ctrl
// Sequencer for the allocator: clearing pass, request decode, memory read
// ordering and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bia_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bia_pkg::sts_t sts,
  output bia_pkg::cmd_t      cmd
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_RING   = 4'd2;
  localparam logic [3:0] ST_RDRING = 4'd3;
  localparam logic [3:0] ST_CLAIM  = 4'd4;
  localparam logic [3:0] ST_RDHEAD = 4'd5;
  localparam logic [3:0] ST_AGE    = 4'd6;
  localparam logic [3:0] ST_RECHK  = 4'd7;
  localparam logic [3:0] ST_NOBUF  = 4'd8;
  localparam logic [3:0] ST_RDID   = 4'd9;
  localparam logic [3:0] ST_AGEI   = 4'd10;
  localparam logic [3:0] ST_CHECK  = 4'd11;
  localparam logic [3:0] ST_DONE   = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = bia_pkg::OP_IDLE;
    cmd.src   = bia_pkg::SRC_ID;
    case (state_r)
      ST_CLEAR: begin
        cmd.op = bia_pkg::OP_CLEAR;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = bia_pkg::OP_LOAD;
          if (sts.in_kind != bia_pkg::KIND_PUT) state_nxt = ST_RDID;
          else if (!sts.free_empty) state_nxt = ST_RING;
          else if (!sts.used_empty) state_nxt = ST_RDHEAD;
          else state_nxt = ST_NOBUF;
        end
      end
      ST_RING: begin
        cmd.op = bia_pkg::OP_RD_RING;
        state_nxt = ST_RDRING;
      end
      ST_RDRING: begin
        cmd.op  = bia_pkg::OP_RD_SLOT;
        cmd.src = bia_pkg::SRC_RING;
        state_nxt = ST_CLAIM;
      end
      ST_CLAIM: begin
        cmd.op = bia_pkg::OP_CLAIM;
        state_nxt = ST_DONE;
      end
      ST_RDHEAD: begin
        cmd.op  = bia_pkg::OP_RD_SLOT;
        cmd.src = bia_pkg::SRC_HEAD;
        state_nxt = ST_AGE;
      end
      ST_AGE: begin
        cmd.op = bia_pkg::OP_AGE;
        state_nxt = ST_RECHK;
      end
      ST_RECHK: begin
        cmd.op = sts.age_gt ? bia_pkg::OP_RECLAIM : bia_pkg::OP_NOBUF;
        state_nxt = ST_DONE;
      end
      ST_NOBUF: begin
        cmd.op = bia_pkg::OP_NOBUF;
        state_nxt = ST_DONE;
      end
      ST_RDID: begin
        cmd.op  = bia_pkg::OP_RD_SLOT;
        cmd.src = bia_pkg::SRC_ID;
        state_nxt = ST_AGEI;
      end
      ST_AGEI: begin
        cmd.op = bia_pkg::OP_AGE;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.op = bia_pkg::OP_CHECK;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.op = bia_pkg::OP_EMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/bia_dp.sv
// ----------------------------------------------------------------------------
// bia_dp
// Datapath: slot memories, free ring, used list pointers, age arithmetic and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bia_dp #(
  parameter int INDEX_BITS = bia_pkg::INDEX_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [31:0]   cfg_wdata,
  input  wire logic [1:0]    in_kind,
  input  wire logic [30:0]   in_ref_id,
  input  wire logic [15:0]   in_packet_handle,
  input  wire logic [31:0]   in_now,
  input  wire logic          in_destroy,
  input  wire logic          out_ready,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [31:0]        out_assigned_id,
  output logic [15:0]        out_got_handle,
  output logic               out_release_valid,
  output logic [15:0]        out_release_handle,
  output logic               out_is_alive,
  input  wire bia_pkg::cmd_t cmd,
  output bia_pkg::sts_t      sts
);

  localparam int IB    = INDEX_BITS;
  localparam int GB    = bia_pkg::ID_BITS - INDEX_BITS;
  localparam int SLOTS = 1 << INDEX_BITS;
  localparam int CB    = INDEX_BITS + 1;
  localparam int HB    = bia_pkg::HANDLE_BITS;
  localparam int TB    = bia_pkg::TIME_BITS;

  // {in_use, guard}
  logic [GB:0]   meta_mem  [SLOTS];
  logic [HB-1:0] hnd_mem   [SLOTS];
  logic [TB-1:0] stamp_mem [SLOTS];
  logic [IB-1:0] nxt_mem   [SLOTS];
  logic [IB-1:0] prv_mem   [SLOTS];
  logic [IB-1:0] ring_mem  [SLOTS];

  logic [GB:0]   meta_q;
  logic [HB-1:0] hnd_q;
  logic [TB-1:0] stamp_q;
  logic [IB-1:0] nxt_q, prv_q, ring_q;

  logic [TB-1:0] timeout_r, timeout_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [30:0]   id_r, id_nxt;
  logic [HB-1:0] handle_r, handle_nxt;
  logic [TB-1:0] now_r, now_nxt;
  logic          destroy_r, destroy_nxt;
  logic [IB-1:0] idx_r, idx_nxt;
  logic [TB-1:0] age_r, age_nxt;
  logic [IB-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CB-1:0] ucnt_r, ucnt_nxt, fcnt_r, fcnt_nxt;
  logic [IB-1:0] rd_r, rd_nxt, wr_r, wr_nxt, clr_r, clr_nxt;

  logic [1:0]    rs_status_r, rs_status_nxt;
  logic [31:0]   rs_id_r, rs_id_nxt;
  logic [HB-1:0] rs_got_r, rs_got_nxt, rs_relh_r, rs_relh_nxt;
  logic          rs_relv_r, rs_relv_nxt, rs_alive_r, rs_alive_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r;
  logic [31:0]   out_id_r;
  logic [HB-1:0] out_got_r, out_relh_r;
  logic          out_relv_r, out_alive_r;

  logic          slot_re, ring_re;
  logic [IB-1:0] slot_addr;
  logic          meta_we, hnd_we, stamp_we, nxt_we, prv_we, ring_we;
  logic [IB-1:0] meta_wa, nxt_wa, prv_wa, ring_wa;
  logic [GB:0]   meta_wd;
  logic [IB-1:0] nxt_wd, prv_wd, ring_wd;
  logic [GB-1:0] guard_inc;
  logic [1:0]    chk_status;

  assign guard_inc = meta_q[GB-1:0] + 1'b1;

  always_comb begin
    case (cmd.src)
      bia_pkg::SRC_RING: slot_addr = ring_q;
      bia_pkg::SRC_HEAD: slot_addr = head_r;
      default:           slot_addr = id_r[IB-1:0];
    endcase
  end

  always_comb begin
    if (!meta_q[GB])                          chk_status = bia_pkg::STAT_UNUSED;
    else if (id_r[30:IB] != meta_q[GB-1:0])   chk_status = bia_pkg::STAT_MISMATCH;
    else                                      chk_status = bia_pkg::STAT_OK;
  end

  always_comb begin
    timeout_nxt = cfg_we ? cfg_wdata : timeout_r;
    kind_nxt = kind_r;  id_nxt = id_r;  handle_nxt = handle_r;
    now_nxt = now_r;    destroy_nxt = destroy_r;
    idx_nxt = idx_r;    age_nxt = age_r;
    head_nxt = head_r;  tail_nxt = tail_r;  ucnt_nxt = ucnt_r;
    rd_nxt = rd_r;      wr_nxt = wr_r;      fcnt_nxt = fcnt_r;
    clr_nxt = clr_r;
    rs_status_nxt = rs_status_r; rs_id_nxt = rs_id_r; rs_got_nxt = rs_got_r;
    rs_relv_nxt = rs_relv_r; rs_relh_nxt = rs_relh_r; rs_alive_nxt = rs_alive_r;
    slot_re = 1'b0; ring_re = 1'b0;
    meta_we = 1'b0; hnd_we = 1'b0; stamp_we = 1'b0;
    nxt_we = 1'b0;  prv_we = 1'b0; ring_we = 1'b0;
    meta_wa = idx_r; meta_wd = meta_q;
    nxt_wa = tail_r; nxt_wd = idx_r;
    prv_wa = idx_r;  prv_wd = tail_r;
    ring_wa = wr_r;  ring_wd = idx_r;
    out_valid_nxt = out_valid_r & ~out_ready;

    case (cmd.op)
      bia_pkg::OP_CLEAR: begin
        meta_we = 1'b1; meta_wa = clr_r; meta_wd = {1'b0, {GB{1'b1}}};
        ring_we = 1'b1; ring_wa = clr_r; ring_wd = clr_r;
        clr_nxt = clr_r + 1'b1;
      end
      bia_pkg::OP_LOAD: begin
        kind_nxt = in_kind; id_nxt = in_ref_id; handle_nxt = in_packet_handle;
        now_nxt = in_now;   destroy_nxt = in_destroy;
      end
      bia_pkg::OP_RD_RING: ring_re = 1'b1;
      bia_pkg::OP_RD_SLOT: begin
        slot_re = 1'b1;
        idx_nxt = slot_addr;
      end
      bia_pkg::OP_AGE: age_nxt = now_r - stamp_q;
      bia_pkg::OP_CLAIM: begin
        meta_we = 1'b1; meta_wd = {1'b1, guard_inc};
        hnd_we = 1'b1; stamp_we = 1'b1;
        if (ucnt_r == '0) begin
          head_nxt = idx_r;
        end else begin
          nxt_we = 1'b1; prv_we = 1'b1;
        end
        tail_nxt = idx_r;
        ucnt_nxt = ucnt_r + 1'b1;
        rd_nxt = rd_r + 1'b1;
        fcnt_nxt = fcnt_r - 1'b1;
        rs_status_nxt = bia_pkg::STAT_OK;
        rs_id_nxt = {1'b0, guard_inc, idx_r};
        rs_got_nxt = '0; rs_relv_nxt = 1'b0; rs_relh_nxt = '0; rs_alive_nxt = 1'b0;
      end
      bia_pkg::OP_RECLAIM: begin
        meta_we = 1'b1; meta_wd = {1'b1, guard_inc};
        hnd_we = 1'b1; stamp_we = 1'b1;
        // head slot moves to the tail; a single-entry list stays as is
        if (ucnt_r != CB'(1)) begin
          head_nxt = nxt_q;
          nxt_we = 1'b1; prv_we = 1'b1;
          tail_nxt = idx_r;
        end
        rs_status_nxt = bia_pkg::STAT_OK;
        rs_id_nxt = {1'b0, guard_inc, idx_r};
        rs_got_nxt = '0; rs_relv_nxt = 1'b1; rs_relh_nxt = hnd_q; rs_alive_nxt = 1'b0;
      end
      bia_pkg::OP_NOBUF: begin
        rs_status_nxt = bia_pkg::STAT_NO_BUFFER;
        rs_id_nxt = bia_pkg::NO_BUFFER_ID;
        rs_got_nxt = '0; rs_relv_nxt = 1'b0; rs_relh_nxt = '0; rs_alive_nxt = 1'b0;
      end
      bia_pkg::OP_CHECK: begin
        rs_status_nxt = chk_status;
        rs_id_nxt = '0;
        rs_got_nxt = '0; rs_relv_nxt = 1'b0; rs_relh_nxt = '0; rs_alive_nxt = 1'b0;
        if (chk_status == bia_pkg::STAT_OK) begin
          if (kind_r == bia_pkg::KIND_ALIVE) begin
            rs_alive_nxt = (age_r < timeout_r);
          end else begin
            if (kind_r == bia_pkg::KIND_GET) begin
              rs_got_nxt = hnd_q;
            end else if (destroy_r) begin
              rs_relv_nxt = 1'b1;
              rs_relh_nxt = hnd_q;
            end
            meta_we = 1'b1; meta_wd = {1'b0, meta_q[GB-1:0]};
            // unlink from the used list
            if (ucnt_r == CB'(1)) begin
              ucnt_nxt = '0;
            end else if (ucnt_r != '0) begin
              if (idx_r == head_r) head_nxt = nxt_q;
              else begin
                nxt_we = 1'b1; nxt_wa = prv_q; nxt_wd = nxt_q;
              end
              if (idx_r == tail_r) tail_nxt = prv_q;
              else begin
                prv_we = 1'b1; prv_wa = nxt_q; prv_wd = prv_q;
              end
              ucnt_nxt = ucnt_r - 1'b1;
            end
            if (fcnt_r != CB'(SLOTS)) begin
              ring_we = 1'b1;
              wr_nxt = wr_r + 1'b1;
              fcnt_nxt = fcnt_r + 1'b1;
            end
          end
        end
      end
      bia_pkg::OP_EMIT: out_valid_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (slot_re) meta_q <= meta_mem[slot_addr];
  end

  always_ff @(posedge clk) begin
    if (hnd_we) hnd_mem[idx_r] <= handle_r;
    if (slot_re) hnd_q <= hnd_mem[slot_addr];
  end

  always_ff @(posedge clk) begin
    if (stamp_we) stamp_mem[idx_r] <= now_r;
    if (slot_re) stamp_q <= stamp_mem[slot_addr];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (slot_re) nxt_q <= nxt_mem[slot_addr];
  end

  always_ff @(posedge clk) begin
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (slot_re) prv_q <= prv_mem[slot_addr];
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_wa] <= ring_wd;
    if (ring_re) ring_q <= ring_mem[rd_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= bia_pkg::TIMEOUT_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      ucnt_r      <= '0;
      rd_r        <= '0;
      wr_r        <= '0;
      fcnt_r      <= CB'(SLOTS);
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      timeout_r   <= timeout_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      ucnt_r      <= ucnt_nxt;
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      fcnt_r      <= fcnt_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt; id_r <= id_nxt; handle_r <= handle_nxt;
    now_r <= now_nxt;   destroy_r <= destroy_nxt;
    idx_r <= idx_nxt;   age_r <= age_nxt;
    rs_status_r <= rs_status_nxt; rs_id_r <= rs_id_nxt; rs_got_r <= rs_got_nxt;
    rs_relv_r <= rs_relv_nxt; rs_relh_r <= rs_relh_nxt; rs_alive_r <= rs_alive_nxt;
    if (cmd.op == bia_pkg::OP_EMIT) begin
      out_status_r <= rs_status_r; out_id_r <= rs_id_r; out_got_r <= rs_got_r;
      out_relv_r <= rs_relv_r; out_relh_r <= rs_relh_r; out_alive_r <= rs_alive_r;
    end
  end

  assign sts.in_kind    = in_kind;
  assign sts.free_empty = (fcnt_r == '0);
  assign sts.used_empty = (ucnt_r == '0);
  assign sts.clr_last   = &clr_r;
  assign sts.age_gt     = (age_r > timeout_r);
  assign sts.out_free   = ~out_valid_r | out_ready;

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_assigned_id    = out_id_r;
  assign out_got_handle     = out_got_r;
  assign out_release_valid  = out_relv_r;
  assign out_release_handle = out_relh_r;
  assign out_is_alive       = out_alive_r;

endmodule

`default_nettype wire

// File: hw/rtl/buffer_id_allocator_with_timeout_top.sv
// ----------------------------------------------------------------------------
// buffer_id_allocator_with_timeout_top
// Generation-guarded packet buffer id allocator with timeout reclaim.
//
// Requests arrive on the in_ channel (valid/ready); each produces exactly one
// result on the out_ channel (valid/ready). cfg_we/cfg_wdata set the timeout
// in ticks and take effect at once; write only while no request is in flight.
// After reset the slot guard and free ring memories are swept, one slot per
// cycle, for 2^INDEX_BITS slots (4096 by default); in_ready is low meanwhile.
// A request goes from the accepting edge to the result register through
// registered memory reads and, but for a put from the free ring, an age
// subtract and check; a put that finds neither a free nor a used slot skips them.
// Only one request is handled at a time, until its result is emitted.
// The result sits in an output register: a stalled receiver does not stop the
// next request being accepted and processed; it waits only to hand its
// result over until the previous transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_id_allocator_with_timeout_top #(
  parameter int INDEX_BITS = bia_pkg::INDEX_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [30:0] in_ref_id,
  input  wire logic [15:0] in_packet_handle,
  input  wire logic [31:0] in_now,
  input  wire logic        in_destroy,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_assigned_id,
  output logic [15:0]      out_got_handle,
  output logic             out_release_valid,
  output logic [15:0]      out_release_handle,
  output logic             out_is_alive
);

  bia_pkg::cmd_t cmd;
  bia_pkg::sts_t sts;

  bia_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bia_dp #(
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_kind            (in_kind),
    .in_ref_id          (in_ref_id),
    .in_packet_handle   (in_packet_handle),
    .in_now             (in_now),
    .in_destroy         (in_destroy),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_assigned_id    (out_assigned_id),
    .out_got_handle     (out_got_handle),
    .out_release_valid  (out_release_valid),
    .out_release_handle (out_release_handle),
    .out_is_alive       (out_is_alive),
    .cmd                (cmd),
    .sts                (sts)
  );

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bia_pkg::STAT_OK) |-> (!out_release_valid && !out_is_alive))
    else $error("failed request reports a release or alive flag");

  a_nobuf_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bia_pkg::STAT_NO_BUFFER) |->
      (out_assigned_id == bia_pkg::NO_BUFFER_ID))
    else $error("no-buffer result without the all-ones id");

  a_emit_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == bia_pkg::OP_EMIT) |-> !in_ready)
    else $error("result emitted while idle");

endmodule

`default_nettype wire
